[rtl/bfsp_pkg.sv]
// shared widths, register codes and record types of the shortest path engine
package bfsp_pkg;

   // fixed field widths
   localparam int NODE_W     = 7;
   localparam int WEIGHT_W   = 16;
   localparam int DIST_W     = 48;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_NODE = 1'b1;

   // configuration reset values
   localparam logic [NODE_W-1:0] NODE_COUNT_RST  = 7'd4;
   localparam logic [NODE_W-1:0] SOURCE_NODE_RST = 7'd1;

   // one stored edge
   typedef struct packed {
      logic [NODE_W-1:0]          from_node;
      logic [NODE_W-1:0]          to_node;
      logic signed [WEIGHT_W-1:0] weight;
   } edge_type;

   // one distance table entry
   typedef struct packed {
      logic                     valid;
      logic signed [DIST_W-1:0] value;
   } dist_type;

   // outcome of relaxing one edge
   typedef struct packed {
      logic                     hit;
      logic signed [DIST_W-1:0] value;
   } relax_type;

   localparam int EDGE_W       = $bits(edge_type);
   localparam int DIST_ENTRY_W = $bits(dist_type);

endpackage

[rtl/bfsp_req_if.sv]
// request channel: edge loads and run commands
interface bfsp_req_if;
   import bfsp_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       mode;
   logic [NODE_W-1:0]          edge_from;
   logic [NODE_W-1:0]          edge_to;
   logic signed [WEIGHT_W-1:0] edge_weight;

   modport source (output valid, mode, edge_from, edge_to, edge_weight, input ready);
   modport sink   (input valid, mode, edge_from, edge_to, edge_weight, output ready);
endinterface

[rtl/bfsp_rsp_if.sv]
// response channel: per-node distances or a negative cycle flag
interface bfsp_rsp_if;
   import bfsp_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [NODE_W-1:0]        node_index;
   logic signed [DIST_W-1:0] path_distance;
   logic                     reachable;
   logic                     negative_cycle;
   logic                     last;

   modport source (output valid, node_index, path_distance, reachable, negative_cycle,
                   last, input ready);
   modport sink   (input valid, node_index, path_distance, reachable, negative_cycle,
                   last, output ready);
endinterface

[rtl/bellman_ford_shortest_path.sv]
// single-source shortest path engine: edge store, distance table and pass sequencer
// Edge load: one transfer per cycle while idle, no response.
// Run: clear the distance table, then for each edge an edge read, a distance read and a write-back,
// over n-1 relaxation passes plus one check pass.
// Results: one per node, each held in the output register until taken, or one negative cycle result.
// Reset clears control state and edge count, sets node_count 4 and source_node 1; memories stay.
module bellman_ford_shortest_path #(
   parameter int MAX_NODES = 64,
   parameter int MAX_EDGES = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   bfsp_req_if.sink                            req_chan,
   bfsp_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [bfsp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bfsp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import bfsp_pkg::*;

   localparam int ETW = $clog2(MAX_EDGES + 1);
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int NAW = $clog2(MAX_NODES);

   localparam logic [NODE_W-1:0] NODE_LIMIT = NODE_W'(MAX_NODES);
   localparam logic [NODE_W-1:0] NODE_ONE   = NODE_W'(1);
   localparam logic [ETW-1:0]    EDGE_LIMIT = ETW'(MAX_EDGES);
   localparam logic [ETW-1:0]    EDGE_ONE   = ETW'(1);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CLEAR  = 3'd1;
   localparam logic [2:0] S_EDGE   = 3'd2;
   localparam logic [2:0] S_DIST   = 3'd3;
   localparam logic [2:0] S_RELAX  = 3'd4;
   localparam logic [2:0] S_NEG    = 3'd5;
   localparam logic [2:0] S_OUT_RD = 3'd6;
   localparam logic [2:0] S_OUT_WR = 3'd7;

   logic [2:0]               state_ff,       state_in;
   logic [NODE_W-1:0]        node_count_ff,  node_count_in;
   logic [NODE_W-1:0]        source_node_ff, source_node_in;
   logic [ETW-1:0]           edge_total_ff,  edge_total_in;
   logic [ETW-1:0]           k_ff,           k_in;
   logic [NODE_W-1:0]        pass_ff,        pass_in;
   logic [NODE_W-1:0]        nd_ff,          nd_in;
   logic                     neg_ff,         neg_in;
   logic                     rsp_valid_ff,   rsp_valid_in;
   logic [NODE_W-1:0]        rsp_node_ff,    rsp_node_in;
   logic signed [DIST_W-1:0] rsp_dist_ff,    rsp_dist_in;
   logic                     rsp_reach_ff,   rsp_reach_in;
   logic                     rsp_neg_ff,     rsp_neg_in;
   logic                     rsp_last_ff,    rsp_last_in;

   logic [NODE_W-1:0]        n_eff;
   logic [NODE_W-1:0]        nd_m1;
   logic [NODE_W-1:0]        from_m1;
   logic [NODE_W-1:0]        to_m1;
   logic                     check_pass;
   logic                     last_edge;

   logic                     edge_we;
   logic                     edge_re;
   edge_type                 edge_wdata;
   logic [EDGE_W-1:0]        edge_rdata;
   edge_type                 cur_edge;

   logic                     dist_we;
   logic [NAW-1:0]           dist_waddr;
   dist_type                 dist_wdata;
   logic                     dist_re;
   logic [NAW-1:0]           dist_raddr_a;
   logic [NAW-1:0]           dist_raddr_b;
   logic [DIST_ENTRY_W-1:0]  dist_rdata_a;
   logic [DIST_ENTRY_W-1:0]  dist_rdata_b;
   dist_type                 dist_a;
   dist_type                 dist_b;
   relax_type                relax;

   // effective node count: zero acts as one, large values clamp
   assign n_eff = (node_count_ff == '0)        ? NODE_ONE :
                  (node_count_ff > NODE_LIMIT) ? NODE_LIMIT : node_count_ff;

   assign cur_edge   = edge_type'(edge_rdata);
   assign dist_a     = dist_type'(dist_rdata_a);
   assign dist_b     = dist_type'(dist_rdata_b);
   assign nd_m1      = nd_ff - NODE_ONE;
   assign from_m1    = cur_edge.from_node - NODE_ONE;
   assign to_m1      = cur_edge.to_node - NODE_ONE;
   assign check_pass = (pass_ff == (n_eff - NODE_ONE));
   assign last_edge  = ((k_ff + EDGE_ONE) == edge_total_ff);

   assign edge_wdata.from_node = req_chan.edge_from;
   assign edge_wdata.to_node   = req_chan.edge_to;
   assign edge_wdata.weight    = req_chan.edge_weight;

   // edge store
   bfsp_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock (clock),
      .we    (edge_we),
      .waddr (edge_total_ff[EAW-1:0]),
      .wdata (edge_wdata),
      .re    (edge_re),
      .raddr (k_ff[EAW-1:0]),
      .rdata (edge_rdata)
   );

   // distance table, two copies for tail and head reads in one cycle
   bfsp_ram #(.WIDTH(DIST_ENTRY_W), .DEPTH(MAX_NODES)) u_dist_ram_a (
      .clock (clock),
      .we    (dist_we),
      .waddr (dist_waddr),
      .wdata (dist_wdata),
      .re    (dist_re),
      .raddr (dist_raddr_a),
      .rdata (dist_rdata_a)
   );

   bfsp_ram #(.WIDTH(DIST_ENTRY_W), .DEPTH(MAX_NODES)) u_dist_ram_b (
      .clock (clock),
      .we    (dist_we),
      .waddr (dist_waddr),
      .wdata (dist_wdata),
      .re    (dist_re),
      .raddr (dist_raddr_b),
      .rdata (dist_rdata_b)
   );

   // relaxation of the edge under test
   bfsp_relax u_relax (
      .edge_rec   (cur_edge),
      .dist_from  (dist_a),
      .dist_to    (dist_b),
      .node_limit (n_eff),
      .result     (relax)
   );

   // channel outputs
   assign req_chan.ready          = (state_ff == S_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.node_index     = rsp_node_ff;
   assign rsp_chan.path_distance  = rsp_dist_ff;
   assign rsp_chan.reachable      = rsp_reach_ff;
   assign rsp_chan.negative_cycle = rsp_neg_ff;
   assign rsp_chan.last           = rsp_last_ff;

   // sequencer next state
   always_comb begin
      state_in       = state_ff;
      node_count_in  = node_count_ff;
      source_node_in = source_node_ff;
      edge_total_in  = edge_total_ff;
      k_in           = k_ff;
      pass_in        = pass_ff;
      nd_in          = nd_ff;
      neg_in         = neg_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_node_in    = rsp_node_ff;
      rsp_dist_in    = rsp_dist_ff;
      rsp_reach_in   = rsp_reach_ff;
      rsp_neg_in     = rsp_neg_ff;
      rsp_last_in    = rsp_last_ff;
      edge_we        = 1'b0;
      edge_re        = 1'b0;
      dist_we        = 1'b0;
      dist_waddr     = '0;
      dist_wdata     = '0;
      dist_re        = 1'b0;
      dist_raddr_a   = '0;
      dist_raddr_b   = '0;

      // configuration writes
      if (csr_we) begin
         case (csr_index)
            CSR_NODE_COUNT:  node_count_in  = csr_wdata;
            CSR_SOURCE_NODE: source_node_in = csr_wdata;
            default: ;
         endcase
      end

      // output register drains on transfer
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               if (!req_chan.mode) begin
                  if (edge_total_ff < EDGE_LIMIT) begin
                     edge_we       = 1'b1;
                     edge_total_in = edge_total_ff + EDGE_ONE;
                  end
               end else begin
                  nd_in    = NODE_ONE;
                  neg_in   = 1'b0;
                  state_in = S_CLEAR;
               end
            end
         end
         // one entry per cycle: only the source starts valid at zero
         S_CLEAR: begin
            dist_we          = 1'b1;
            dist_waddr       = nd_m1[NAW-1:0];
            dist_wdata.valid = (nd_ff == source_node_ff);
            dist_wdata.value = '0;
            if (nd_ff == n_eff) begin
               nd_in    = NODE_ONE;
               k_in     = '0;
               pass_in  = '0;
               state_in = (edge_total_ff == '0) ? S_OUT_RD : S_EDGE;
            end else begin
               nd_in = nd_ff + NODE_ONE;
            end
         end
         S_EDGE: begin
            edge_re  = 1'b1;
            state_in = S_DIST;
         end
         S_DIST: begin
            dist_re      = 1'b1;
            dist_raddr_a = from_m1[NAW-1:0];
            dist_raddr_b = to_m1[NAW-1:0];
            state_in     = S_RELAX;
         end
         // write back an improvement, or flag it during the check pass
         S_RELAX: begin
            if (relax.hit) begin
               if (check_pass) begin
                  neg_in = 1'b1;
               end else begin
                  dist_we          = 1'b1;
                  dist_waddr       = to_m1[NAW-1:0];
                  dist_wdata.valid = 1'b1;
                  dist_wdata.value = relax.value;
               end
            end
            if (last_edge) begin
               k_in = '0;
               if (check_pass) begin
                  edge_total_in = '0;
                  state_in      = (neg_ff || relax.hit) ? S_NEG : S_OUT_RD;
               end else begin
                  pass_in  = pass_ff + NODE_ONE;
                  state_in = S_EDGE;
               end
            end else begin
               k_in     = k_ff + EDGE_ONE;
               state_in = S_EDGE;
            end
         end
         S_NEG: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_node_in  = '0;
               rsp_dist_in  = '0;
               rsp_reach_in = 1'b0;
               rsp_neg_in   = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         // read one node once the output register is free
         S_OUT_RD: begin
            if (!rsp_valid_ff) begin
               dist_re      = 1'b1;
               dist_raddr_a = nd_m1[NAW-1:0];
               state_in     = S_OUT_WR;
            end
         end
         S_OUT_WR: begin
            rsp_valid_in = 1'b1;
            rsp_node_in  = nd_ff;
            rsp_dist_in  = dist_a.valid ? dist_a.value : '0;
            rsp_reach_in = dist_a.valid;
            rsp_neg_in   = 1'b0;
            rsp_last_in  = (nd_ff == n_eff);
            if (nd_ff == n_eff) begin
               state_in = S_IDLE;
            end else begin
               nd_in    = nd_ff + NODE_ONE;
               state_in = S_OUT_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         node_count_ff  <= NODE_COUNT_RST;
         source_node_ff <= SOURCE_NODE_RST;
         edge_total_ff  <= '0;
         neg_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         node_count_ff  <= node_count_in;
         source_node_ff <= source_node_in;
         edge_total_ff  <= edge_total_in;
         neg_ff         <= neg_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // counters and result payload
   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      pass_ff      <= pass_in;
      nd_ff        <= nd_in;
      rsp_node_ff  <= rsp_node_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_reach_ff <= rsp_reach_in;
      rsp_neg_ff   <= rsp_neg_in;
      rsp_last_ff  <= rsp_last_in;
   end

`ifndef SYNTHESIS
   // a result is only loaded into an empty output register
   a_out_load_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT_WR) |-> !rsp_valid_ff)
      else $error("result loaded over a pending result");

   // edge count never passes the store depth
   a_edge_total_bound: assert property (@(posedge clock) disable iff (reset)
      (edge_total_ff <= EDGE_LIMIT))
      else $error("edge count beyond store depth");

   // a finished run leaves the edge store empty
   a_run_empties: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_IDLE) && ($past(state_ff) != S_IDLE)) |-> (edge_total_ff == '0))
      else $error("edge store not emptied after run");

   // the relaxation pass never goes past the check pass
   a_pass_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RELAX) |-> (pass_ff < n_eff))
      else $error("pass counter beyond check pass");
`endif
endmodule

[rtl/bfsp_ram.sv]
// generic single write, single read ram with registered read data
module bfsp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic                                    re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end
endmodule

[rtl/bfsp_relax.sv]
// relaxation datapath: candidate distance and improvement test for one edge
module bfsp_relax (
   input  bfsp_pkg::edge_type           edge_rec,
   input  bfsp_pkg::dist_type           dist_from,
   input  bfsp_pkg::dist_type           dist_to,
   input  logic [bfsp_pkg::NODE_W-1:0]  node_limit,
   output bfsp_pkg::relax_type          result
);
   import bfsp_pkg::*;

   logic                     in_range;
   logic signed [DIST_W-1:0] weight_ext;
   logic signed [DIST_W-1:0] cand;

   // edge endpoints must lie within the active node range
   assign in_range = (edge_rec.from_node != '0) && (edge_rec.from_node <= node_limit) &&
                     (edge_rec.to_node != '0) && (edge_rec.to_node <= node_limit);

   // sign extended weight added to tail distance
   assign weight_ext = $signed({{(DIST_W-WEIGHT_W){edge_rec.weight[WEIGHT_W-1]}},
                                edge_rec.weight});
   assign cand       = dist_from.value + weight_ext;

   // improvement when tail is reached and head is unreached or farther
   assign result.hit   = in_range && dist_from.valid &&
                         (!dist_to.valid || (dist_to.value > cand));
   assign result.value = cand;
endmodule
